// ===== hw/rtl/clws_pkg.sv =====
`timescale 1ns / 1ps

package clws_pkg;

    // Widths of the configuration port, of the tick counts and of the microcode address.
    localparam int CFG_IDX_W = 3;
    localparam int TICK_W    = 20;
    localparam int UPC_W     = 5;

    // Request types.
    localparam logic [1:0] REQ_CMD    = 2'd0;
    localparam logic [1:0] REQ_DATA   = 2'd1;
    localparam logic [1:0] REQ_CURSOR = 2'd2;
    localparam logic [1:0] REQ_POWER  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BUS_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_WAIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON  = 3'd4;

    // Display command bytes and cursor row base addresses.
    localparam logic [7:0] LCD_CLEAR      = 8'h01;
    localparam logic [7:0] LCD_FUNC_8BIT  = 8'h38;
    localparam logic [7:0] LCD_FUNC_4BIT  = 8'h28;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0E;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
    localparam logic [7:0] LCD_WAKE_3     = 8'h30;
    localparam logic [7:0] LCD_WAKE_2     = 8'h20;
    localparam logic [7:0] ROW1_BASE      = 8'h80;
    localparam logic [7:0] ROW2_BASE      = 8'hC0;
    localparam logic [3:0] NIBBLE_MASK    = 4'hF;

    // Configuration snapshot handed to the sequencer.
    typedef struct packed {
        logic              bus_4bit;
        logic [TICK_W-1:0] enable_ticks;
        logic [TICK_W-1:0] settle_ticks;
        logic [TICK_W-1:0] long_wait_ticks;
        logic [TICK_W-1:0] power_on_ticks;
    } t_cfg;

    // Microcode fields.
    typedef enum logic {OP_PULSE, OP_POWER} t_op;
    typedef enum logic {SRC_REQ, SRC_LIT} t_src;
    typedef enum logic [1:0] {NIB_FULL, NIB_HI, NIB_LO} t_nib;
    typedef enum logic [1:0] {WAIT_SETTLE, WAIT_LONG, WAIT_CLEAR} t_wait;

    typedef struct packed {
        t_op        op;
        t_src       src;
        t_nib       nib;
        t_wait      wait_sel;
        logic [7:0] lit;
        logic       is_end;
    } t_uword;

    // Program entry points.
    localparam logic [UPC_W-1:0] UA_BYTE8 = 5'd0;
    localparam logic [UPC_W-1:0] UA_BYTE4 = 5'd1;
    localparam logic [UPC_W-1:0] UA_PWR8  = 5'd3;
    localparam logic [UPC_W-1:0] UA_PWR4  = 5'd7;

    // Microcode store: one pulse (or the power-on wait) per word.
    function automatic t_uword uop_rom(input logic [UPC_W-1:0] addr);
        t_uword w;
        w = '{OP_PULSE, SRC_REQ, NIB_FULL, WAIT_SETTLE, 8'h00, 1'b1};
        unique case (addr)
            // Byte on the 8-bit bus.
            5'd0:  w = '{OP_PULSE, SRC_REQ, NIB_FULL, WAIT_CLEAR,  8'h00, 1'b1};
            // Byte on the 4-bit bus, high nibble then low nibble.
            5'd1:  w = '{OP_PULSE, SRC_REQ, NIB_HI,   WAIT_SETTLE, 8'h00, 1'b0};
            5'd2:  w = '{OP_PULSE, SRC_REQ, NIB_LO,   WAIT_CLEAR,  8'h00, 1'b1};
            // Power-up on the 8-bit bus.
            5'd3:  w = '{OP_POWER, SRC_LIT, NIB_FULL, WAIT_LONG, 8'h00, 1'b0};
            5'd4:  w = '{OP_PULSE, SRC_LIT, NIB_FULL, WAIT_LONG, LCD_FUNC_8BIT, 1'b0};
            5'd5:  w = '{OP_PULSE, SRC_LIT, NIB_FULL, WAIT_LONG, LCD_DISP_ON, 1'b0};
            5'd6:  w = '{OP_PULSE, SRC_LIT, NIB_FULL, WAIT_LONG, LCD_CLEAR, 1'b1};
            // Power-up on the 4-bit bus: wake-up nibbles, then full bytes.
            5'd7:  w = '{OP_POWER, SRC_LIT, NIB_FULL, WAIT_LONG, 8'h00, 1'b0};
            5'd8:  w = '{OP_PULSE, SRC_LIT, NIB_FULL, WAIT_LONG, LCD_WAKE_3, 1'b0};
            5'd9:  w = '{OP_PULSE, SRC_LIT, NIB_FULL, WAIT_LONG, LCD_WAKE_3, 1'b0};
            5'd10: w = '{OP_PULSE, SRC_LIT, NIB_FULL, WAIT_LONG, LCD_WAKE_3, 1'b0};
            5'd11: w = '{OP_PULSE, SRC_LIT, NIB_FULL, WAIT_LONG, LCD_WAKE_2, 1'b0};
            5'd12: w = '{OP_PULSE, SRC_LIT, NIB_HI, WAIT_SETTLE, LCD_FUNC_4BIT, 1'b0};
            5'd13: w = '{OP_PULSE, SRC_LIT, NIB_LO, WAIT_LONG,   LCD_FUNC_4BIT, 1'b0};
            5'd14: w = '{OP_PULSE, SRC_LIT, NIB_HI, WAIT_SETTLE, LCD_DISP_ON, 1'b0};
            5'd15: w = '{OP_PULSE, SRC_LIT, NIB_LO, WAIT_LONG,   LCD_DISP_ON, 1'b0};
            5'd16: w = '{OP_PULSE, SRC_LIT, NIB_HI, WAIT_SETTLE, LCD_CLEAR, 1'b0};
            5'd17: w = '{OP_PULSE, SRC_LIT, NIB_LO, WAIT_LONG,   LCD_CLEAR, 1'b0};
            5'd18: w = '{OP_PULSE, SRC_LIT, NIB_HI, WAIT_SETTLE, LCD_ENTRY_MODE, 1'b0};
            5'd19: w = '{OP_PULSE, SRC_LIT, NIB_LO, WAIT_LONG,   LCD_ENTRY_MODE, 1'b1};
            default: w = '{OP_PULSE, SRC_REQ, NIB_FULL, WAIT_SETTLE, 8'h00, 1'b1};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/clws_ifs.sv =====
`timescale 1ns / 1ps

// Request channel.
interface clws_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic [1:0] row;
    logic [6:0] column;

    modport source (output valid, req_type, data_byte, row, column, input ready);
    modport sink   (input valid, req_type, data_byte, row, column, output ready);
endinterface

// Bus phase channel.
interface clws_phase_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_pins;
    logic        reg_select;
    logic        read_write;
    logic        enable;
    logic [19:0] hold_ticks;
    logic        last;

    modport source (output valid, data_pins, reg_select, read_write, enable, hold_ticks,
                    last, input ready);
    modport sink   (input valid, data_pins, reg_select, read_write, enable, hold_ticks,
                    last, output ready);
endinterface

// Configuration write channel.
interface clws_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [19:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/clws_sequencer.sv =====
`timescale 1ns / 1ps

module clws_sequencer
    import clws_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    clws_req_if.sink         i_req,
    clws_phase_if.source     o_phase
);

    logic             r_busy, n_busy;
    logic [UPC_W-1:0] r_pc, n_pc;
    logic             r_phase, n_phase;
    logic [7:0]       r_byte, n_byte;
    logic             r_rs, n_rs;
    logic             r_clear, n_clear;

    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_out_pins, n_out_pins;
    logic              r_out_rs, n_out_rs;
    logic              r_out_en, n_out_en;
    logic [TICK_W-1:0] r_out_hold, n_out_hold;
    logic              r_out_last, n_out_last;

    t_uword            w;
    logic [7:0]        src_byte;
    logic [7:0]        pins;
    logic [TICK_W-1:0] low_hold;
    logic              emit;
    logic              step_done;
    logic              accept;
    logic              has_out;
    logic [UPC_W-1:0]  entry;
    logic [7:0]        cursor_addr;

    assign i_req.ready = !r_busy;
    assign accept      = i_req.valid && !r_busy;

    // Decode the request into its first microcode address.
    always_comb begin
        cursor_addr = ((i_req.row == 2'd1) ? ROW1_BASE : ROW2_BASE)
                      + {1'b0, i_req.column} - 8'd1;
        has_out = (i_req.req_type != REQ_CURSOR) || (i_req.row == 2'd1)
                  || (i_req.row == 2'd2);
        if (i_req.req_type == REQ_POWER) begin
            entry = i_cfg.bus_4bit ? UA_PWR4 : UA_PWR8;
        end else begin
            entry = i_cfg.bus_4bit ? UA_BYTE4 : UA_BYTE8;
        end
    end

    // Datapath driven by the current control word.
    always_comb begin
        w        = uop_rom(r_pc);
        src_byte = (w.src == SRC_REQ) ? r_byte : w.lit;
        unique case (w.nib)
            NIB_HI:  pins = {src_byte[7:4], 4'h0};
            NIB_LO:  pins = {src_byte[3:0], 4'h0};
            default: pins = src_byte;
        endcase
        unique case (w.wait_sel)
            WAIT_LONG:  low_hold = i_cfg.long_wait_ticks;
            WAIT_CLEAR: low_hold = r_clear ? i_cfg.long_wait_ticks : i_cfg.settle_ticks;
            default:    low_hold = i_cfg.settle_ticks;
        endcase
        emit      = r_busy && (!r_out_valid || o_phase.ready);
        step_done = (w.op == OP_POWER) || r_phase;
    end

    // Step counter, phase toggle and output register updates.
    always_comb begin
        n_busy      = r_busy;
        n_pc        = r_pc;
        n_phase     = r_phase;
        n_byte      = r_byte;
        n_rs        = r_rs;
        n_clear     = r_clear;
        n_out_valid = r_out_valid;
        n_out_pins  = r_out_pins;
        n_out_rs    = r_out_rs;
        n_out_en    = r_out_en;
        n_out_hold  = r_out_hold;
        n_out_last  = r_out_last;

        if (r_out_valid && o_phase.ready) begin
            n_out_valid = 1'b0;
        end

        if (emit) begin
            n_out_valid = 1'b1;
            if (w.op == OP_POWER) begin
                n_out_pins = 8'h00;
                n_out_rs   = 1'b0;
                n_out_en   = 1'b0;
                n_out_hold = i_cfg.power_on_ticks;
            end else begin
                n_out_pins = pins;
                n_out_rs   = r_rs;
                n_out_en   = !r_phase;
                n_out_hold = r_phase ? low_hold : i_cfg.enable_ticks;
            end
            n_out_last = w.is_end && step_done;
            if (step_done) begin
                n_phase = 1'b0;
                if (w.is_end) begin
                    n_busy = 1'b0;
                end else begin
                    n_pc = r_pc + 1'b1;
                end
            end else begin
                n_phase = 1'b1;
            end
        end

        if (accept) begin
            n_busy  = has_out;
            n_pc    = entry;
            n_phase = 1'b0;
            n_byte  = (i_req.req_type == REQ_CURSOR) ? cursor_addr : i_req.data_byte;
            n_rs    = (i_req.req_type == REQ_DATA);
            n_clear = (i_req.req_type == REQ_CMD) && (i_req.data_byte == LCD_CLEAR);
        end
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= UA_BYTE8;
            r_phase     <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
            r_pc        <= n_pc;
            r_phase     <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_rs       <= n_rs;
        r_clear    <= n_clear;
        r_out_pins <= n_out_pins;
        r_out_rs   <= n_out_rs;
        r_out_en   <= n_out_en;
        r_out_hold <= n_out_hold;
        r_out_last <= n_out_last;
    end

    assign o_phase.valid      = r_out_valid;
    assign o_phase.data_pins  = r_out_pins;
    assign o_phase.reg_select = r_out_rs;
    assign o_phase.read_write = 1'b0;
    assign o_phase.enable     = r_out_en;
    assign o_phase.hold_ticks = r_out_hold;
    assign o_phase.last       = r_out_last;

endmodule

// ===== hw/rtl/char_lcd_write_sequencer.sv =====
// Character LCD write sequencer for a parallel HD44780-style bus.
// i_req carries one request per transaction: a command byte, a data byte,
// a cursor move (rows 1 and 2 only; other rows are accepted and give
// nothing) or the power-up sequence. o_phase carries one held bus state per
// transaction: data pins, RS, RW, EN, the hold time in ticks and a last flag
// on the final phase of a request. i_cfg writes the bus mode and the tick
// registers; a tick value of zero is stored as one. It is always ready.
// The request is first loaded into the step state, and its first phase is
// then registered in the output register. A small microcode program walks
// one pulse per step and emits one phase per cycle while the receiver does
// not stall; a request has 2 phases (8-bit byte), 4 (4-bit byte), or 7 or
// 25 (power-up). The next request is taken as soon as the last phase is in
// the output register.
// When the receiver stalls, the output register holds and the sequencer
// waits. Reset empties the output register, drops any request in progress
// and loads the default registers (4-bit bus, 100/50/100000/40000 ticks).
`timescale 1ns / 1ps

module char_lcd_write_sequencer
    import clws_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    clws_req_if.sink     i_req,
    clws_phase_if.source o_phase,
    clws_cfg_if.sink     i_cfg
);

    t_cfg              r_cfg;
    logic [TICK_W-1:0] cfg_ticks;

    // A zero tick count behaves as one tick.
    assign cfg_ticks   = (i_cfg.data == '0) ? TICK_W'(1) : i_cfg.data;
    assign i_cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bus_4bit        <= 1'b1;
            r_cfg.enable_ticks    <= TICK_W'(100);
            r_cfg.settle_ticks    <= TICK_W'(50);
            r_cfg.long_wait_ticks <= TICK_W'(100000);
            r_cfg.power_on_ticks  <= TICK_W'(40000);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_BUS_MODE:  r_cfg.bus_4bit        <= i_cfg.data[0];
                CFG_ENABLE:    r_cfg.enable_ticks    <= cfg_ticks;
                CFG_SETTLE:    r_cfg.settle_ticks    <= cfg_ticks;
                CFG_LONG_WAIT: r_cfg.long_wait_ticks <= cfg_ticks;
                CFG_POWER_ON:  r_cfg.power_on_ticks  <= cfg_ticks;
                default: ;
            endcase
        end
    end

    clws_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_req   (i_req),
        .o_phase (o_phase)
    );

    // The final phase of a request always leaves EN low.
    a_last_en_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_phase.valid && o_phase.last |-> !o_phase.enable)
        else $error("last phase with EN high");

    // Every phase is held for at least one tick.
    a_hold_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_phase.valid |-> o_phase.hold_ticks != '0)
        else $error("phase with zero hold");

    // An EN-high phase is followed by an EN-low phase with the same pins.
    a_pulse_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_phase.valid && o_phase.ready && o_phase.enable |=>
            o_phase.valid && !o_phase.enable
            && o_phase.data_pins == $past(o_phase.data_pins))
        else $error("EN pulse without matching low phase");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import clws_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam logic [1:0] ROW_FIRST = 2'd1;
    localparam logic [1:0] ROW_SECOND = 2'd2;
    localparam logic [19:0] TICKS_MAX = 20'hFFFFF;

    // One display request as offered on the request channel.
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic [1:0] row;
        logic [6:0] column;
    } t_lcd_req;

    // One held bus state as seen on the phase channel.
    typedef struct packed {
        logic [7:0]  pins;
        logic        rs;
        logic        rw;
        logic        en;
        logic [19:0] hold;
        logic        last;
    } t_bus_phase;

    // Turns each accepted request into the bus phases it must produce and
    // compares the phases that come out against them, oldest first.
    class phase_scoreboard;
        logic        four_bit;
        logic [19:0] enable_t;
        logic [19:0] settle_t;
        logic [19:0] long_t;
        logic [19:0] power_t;
        t_bus_phase  pending_phases[$];
        t_bus_phase  burst[$];
        int          mismatches;

        function new();
            four_bit = 1'b1;
            enable_t = 20'd100;
            settle_t = 20'd50;
            long_t = 20'd100000;
            power_t = 20'd40000;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [19:0] val);
            case (idx)
                CFG_BUS_MODE:  four_bit = val[0];
                CFG_ENABLE:    enable_t = val;
                CFG_SETTLE:    settle_t = val;
                CFG_LONG_WAIT: long_t = val;
                CFG_POWER_ON:  power_t = val;
                default: ;
            endcase
        endfunction

        // A tick register that holds zero behaves as one.
        function void add_phase(logic [7:0] pins, logic rs, logic en, logic [19:0] hold);
            t_bus_phase p;
            p.pins = pins;
            p.rs = rs;
            p.rw = 1'b0;
            p.en = en;
            p.hold = (hold == 20'd0) ? 20'd1 : hold;
            p.last = 1'b0;
            burst.push_back(p);
        endfunction

        function void strobe(logic [7:0] pins, logic rs, logic long_wait);
            add_phase(pins, rs, 1'b1, enable_t);
            add_phase(pins, rs, 1'b0, long_wait ? long_t : settle_t);
        endfunction

        // Only the final nibble of a byte can carry the long wait.
        function void send_byte(logic [7:0] b, logic rs, logic long_wait);
            if (!four_bit) begin
                strobe(b, rs, long_wait);
            end else begin
                strobe({b[7:4], 4'h0}, rs, 1'b0);
                strobe({b[3:0], 4'h0}, rs, long_wait);
            end
        endfunction

        function void predict_phases(t_lcd_req r);
            logic [7:0] addr;
            burst.delete();
            case (r.req_type)
                REQ_CMD:  send_byte(r.data_byte, 1'b0, r.data_byte == LCD_CLEAR);
                REQ_DATA: send_byte(r.data_byte, 1'b1, 1'b0);
                REQ_CURSOR: begin
                    if (r.row == ROW_FIRST || r.row == ROW_SECOND) begin
                        addr = (r.row == ROW_FIRST) ? ROW1_BASE : ROW2_BASE;
                        addr = addr + 8'(r.column) - 8'd1;
                        send_byte(addr, 1'b0, 1'b0);
                    end
                end
                default: begin
                    add_phase(8'h00, 1'b0, 1'b0, power_t);
                    if (!four_bit) begin
                        send_byte(LCD_FUNC_8BIT, 1'b0, 1'b1);
                        send_byte(LCD_DISP_ON, 1'b0, 1'b1);
                        send_byte(LCD_CLEAR, 1'b0, 1'b1);
                    end else begin
                        strobe(LCD_WAKE_3, 1'b0, 1'b1);
                        strobe(LCD_WAKE_3, 1'b0, 1'b1);
                        strobe(LCD_WAKE_3, 1'b0, 1'b1);
                        strobe(LCD_WAKE_2, 1'b0, 1'b1);
                        send_byte(LCD_FUNC_4BIT, 1'b0, 1'b1);
                        send_byte(LCD_DISP_ON, 1'b0, 1'b1);
                        send_byte(LCD_CLEAR, 1'b0, 1'b1);
                        send_byte(LCD_ENTRY_MODE, 1'b0, 1'b1);
                    end
                end
            endcase
            foreach (burst[i]) begin
                t_bus_phase p;
                p = burst[i];
                p.last = (i == burst.size() - 1);
                pending_phases.push_back(p);
            end
        endfunction

        task report(string what);
            $display("MISMATCH at %0t ns: %s", $time, what);
            mismatches++;
        endtask

        task check_phase(t_bus_phase got);
            t_bus_phase want;
            if (pending_phases.size() == 0) begin
                report($sformatf("unexpected phase pins=%02h rs=%0b en=%0b hold=%0d last=%0b",
                                 got.pins, got.rs, got.en, got.hold, got.last));
            end else begin
                want = pending_phases.pop_front();
                if (got.pins !== want.pins)
                    report($sformatf("data_pins %02h, wanted %02h", got.pins, want.pins));
                if (got.rs !== want.rs)
                    report($sformatf("reg_select %0b, wanted %0b", got.rs, want.rs));
                if (got.rw !== want.rw)
                    report($sformatf("read_write %0b, wanted %0b", got.rw, want.rw));
                if (got.en !== want.en)
                    report($sformatf("enable %0b, wanted %0b", got.en, want.en));
                if (got.hold !== want.hold)
                    report($sformatf("hold_ticks %0d, wanted %0d", got.hold, want.hold));
                if (got.last !== want.last)
                    report($sformatf("last %0b, wanted %0b", got.last, want.last));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycles = 0;
    int   src_idle_pct = 0;
    int   snk_stall_pct = 0;
    int   hold_left = 0;
    bit   hold_request = 1'b0;
    bit   hold_started = 1'b0;
    phase_scoreboard sb = new();

    clws_req_if   req_if();
    clws_phase_if phase_if();
    clws_cfg_if   cfg_if();

    char_lcd_write_sequencer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_phase (phase_if),
        .i_cfg   (cfg_if)
    );

    // Clock with an 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Run limit in case the block hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off once it is requested.
    always @(posedge i_clk) begin
        if (hold_request && !hold_started) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_started = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            phase_if.ready <= 1'b0;
        end else begin
            phase_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Every phase transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && phase_if.valid && phase_if.ready) begin
            sb.check_phase('{phase_if.data_pins, phase_if.reg_select, phase_if.read_write,
                             phase_if.enable, phase_if.hold_ticks, phase_if.last});
        end
    end

    // Offers one request, idling first at the current rate, and returns at
    // the edge of its transaction with valid still high.
    task automatic send_req(input t_lcd_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= r.req_type;
        req_if.data_byte <= r.data_byte;
        req_if.row <= r.row;
        req_if.column <= r.column;
        do @(posedge i_clk); while (!req_if.ready);
        sb.predict_phases(r);
    endtask

    task automatic send_fields(input logic [1:0] kind, input logic [7:0] b,
                               input logic [1:0] row, input logic [6:0] col);
        send_req('{kind, b, row, col});
    endtask

    // Mostly well-formed requests; cursor moves mostly on real rows.
    function automatic t_lcd_req random_req();
        t_lcd_req r;
        int pick;
        r.data_byte = 8'($urandom());
        r.row = 2'($urandom());
        r.column = 7'($urandom());
        pick = $urandom_range(99);
        if (pick < 30) begin
            r.req_type = REQ_CMD;
            if ($urandom_range(5) == 0)
                r.data_byte = LCD_CLEAR;
        end else if (pick < 65) begin
            r.req_type = REQ_DATA;
        end else if (pick < 92) begin
            r.req_type = REQ_CURSOR;
            if ($urandom_range(9) != 0)
                r.row = 2'($urandom_range(2, 1));
            if ($urandom_range(7) != 0)
                r.column = 7'($urandom_range(64, 1));
        end else begin
            r.req_type = REQ_POWER;
        end
        return r;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_req(random_req());
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [19:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg(idx, val);
    endtask

    // Writes every register; bus mode carries random junk above bit zero.
    // With stray set, the unused indexes are written as well.
    task automatic configure(input logic four_bit, input logic [19:0] en_t,
                             input logic [19:0] settle_t, input logic [19:0] long_t,
                             input logic [19:0] power_t, input bit stray);
        write_cfg(CFG_BUS_MODE, {19'($urandom()), four_bit});
        write_cfg(CFG_ENABLE, en_t);
        write_cfg(CFG_SETTLE, settle_t);
        write_cfg(CFG_LONG_WAIT, long_t);
        write_cfg(CFG_POWER_ON, power_t);
        if (stray) begin
            for (int k = CFG_POWER_ON + 1; k < 8; k++)
                write_cfg(3'(k), 20'($urandom()));
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Stops offering and lets every predicted phase come out.
    task automatic drain();
        req_if.valid <= 1'b0;
        while (sb.pending_phases.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idling(input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.req_type <= REQ_CMD;
        req_if.data_byte <= 8'h00;
        req_if.row <= 2'd0;
        req_if.column <= 7'd0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= CFG_BUS_MODE;
        cfg_if.data <= 20'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings on the 4-bit bus: byte extremes, clear, every
        // cursor row, column wrap in both directions and the power-up.
        set_idling(0, 0);
        send_fields(REQ_CMD, 8'h00, 2'd0, 7'd0);
        send_fields(REQ_CMD, 8'hFF, 2'd3, 7'h7F);
        send_fields(REQ_CMD, LCD_CLEAR, 2'd0, 7'd1);
        send_fields(REQ_DATA, 8'h00, 2'd0, 7'd0);
        send_fields(REQ_DATA, 8'hFF, 2'd3, 7'h7F);
        send_fields(REQ_DATA, 8'hA5, 2'd1, 7'd5);
        send_fields(REQ_CURSOR, 8'h00, ROW_FIRST, 7'd1);
        send_fields(REQ_CURSOR, 8'hFF, ROW_FIRST, 7'd64);
        send_fields(REQ_CURSOR, 8'h00, ROW_SECOND, 7'd1);
        send_fields(REQ_CURSOR, 8'h00, ROW_SECOND, 7'd64);
        send_fields(REQ_CURSOR, 8'h00, 2'd0, 7'd5);
        send_fields(REQ_CURSOR, 8'h00, 2'd3, 7'd7);
        send_fields(REQ_CURSOR, 8'h00, ROW_FIRST, 7'd0);
        send_fields(REQ_CURSOR, 8'h00, ROW_SECOND, 7'h7F);
        send_fields(REQ_POWER, 8'h00, 2'd0, 7'd0);
        drain();

        // 8-bit bus with every tick register at its minimum.
        configure(1'b0, 20'd1, 20'd1, 20'd1, 20'd1, 1'b0);
        send_fields(REQ_POWER, 8'h00, 2'd0, 7'd0);
        send_fields(REQ_CMD, LCD_CLEAR, 2'd0, 7'd0);
        send_fields(REQ_DATA, 8'h5A, 2'd0, 7'd0);
        send_fields(REQ_CURSOR, 8'h00, ROW_SECOND, 7'd40);
        set_idling(74, 0);
        send_random(60);
        drain();

        // 4-bit bus with every tick register at its maximum.
        configure(1'b1, TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX, 1'b0);
        set_idling(0, 74);
        send_random(60);
        drain();

        // Tick registers written as zero, and the unused indexes written.
        configure(1'b0, 20'd0, 20'd0, 20'd0, 20'd0, 1'b1);
        set_idling(31, 31);
        send_random(60);
        drain();

        // Receiver holds off for a long stretch while requests keep coming,
        // so the block backs up and stalls the request channel.
        configure(1'b1, 20'($urandom_range(1048575, 1)), 20'($urandom_range(1048575, 1)),
                  20'($urandom_range(1048575, 1)), 20'($urandom_range(1048575, 1)), 1'b0);
        set_idling(0, 0);
        hold_request = 1'b1;
        send_random(60);
        drain();

        configure(1'b0, 20'($urandom()), 20'($urandom()), 20'($urandom()),
                  20'($urandom()), 1'b1);
        set_idling(31, 31);
        send_random(20);
        drain();

        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
